// ===== hw/rtl/sahs_pkg.sv =====
// Shared types, codes and reset constants for the servo action/hold sequencer.
`timescale 1ns / 1ps

package sahs_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned AngleW = 8;
  localparam int unsigned TicksW = 16;

  // Register reset values
  localparam logic [AngleW-1:0] StandbyAngleRst = 8'd90;
  localparam logic [AngleW-1:0] ClosedAngleRst  = 8'd0;
  localparam logic [AngleW-1:0] OpenAngleRst    = 8'd180;
  localparam logic [AngleW-1:0] SosAngleRst     = 8'd135;
  localparam logic [TicksW-1:0] CurtainHoldRst  = 16'd1000;
  localparam logic [TicksW-1:0] SosHoldRst      = 16'd1000;
  localparam logic [TicksW-1:0] StopHoldRst     = 16'd500;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STANDBY_ANGLE  = 3'd0,
    CFG_CLOSED_ANGLE   = 3'd1,
    CFG_OPEN_ANGLE     = 3'd2,
    CFG_SOS_ANGLE      = 3'd3,
    CFG_CURTAIN_HOLD   = 3'd4,
    CFG_SOS_HOLD       = 3'd5,
    CFG_STOP_HOLD      = 3'd6
  } cfg_idx_e;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_CURTAIN = 2'd1,
    CMD_HELP    = 2'd2
  } in_cmd_e;

  // Latched command
  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_CLOSE = 2'd1,
    HELD_OPEN  = 2'd2,
    HELD_HELP  = 2'd3
  } held_cmd_e;

  // Sequencer phase
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_MOVING   = 2'd1,
    PH_STOPPING = 2'd2
  } phase_e;

  typedef struct packed {
    logic [AngleW-1:0] rest_angle;
    logic [AngleW-1:0] close_angle;
    logic [AngleW-1:0] open_angle;
    logic [AngleW-1:0] help_angle;
    logic [TicksW-1:0] curtain_hold_ticks;
    logic [TicksW-1:0] sos_hold_ticks;
    logic [TicksW-1:0] stop_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       enable_flag;
    logic       condition;
  } item_t;

  typedef struct packed {
    logic [AngleW-1:0] servo_angle;
    logic              angle_written;
    logic              drive_attached;
    logic              moving;
    logic [1:0]        held_command;
  } result_t;

endpackage

// ===== hw/rtl/sahs_in_if.sv =====
// Input channel interface: one request or tick per transaction.
`timescale 1ns / 1ps

interface sahs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       enable_flag;
  logic       condition;

  modport source (output valid, output cmd, output enable_flag, output condition,
                  input ready);
  modport sink   (input valid, input cmd, input enable_flag, input condition,
                  output ready);
endinterface

// ===== hw/rtl/sahs_out_if.sv =====
// Result channel interface: servo status after each input transaction.
`timescale 1ns / 1ps

interface sahs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] servo_angle;
  logic       angle_written;
  logic       drive_attached;
  logic       moving;
  logic [1:0] held_command;

  modport source (output valid, output servo_angle, output angle_written,
                  output drive_attached, output moving, output held_command,
                  input ready);
  modport sink   (input valid, input servo_angle, input angle_written,
                  input drive_attached, input moving, input held_command,
                  output ready);
endinterface

// ===== hw/rtl/sahs_cfg.sv =====
// Configuration register file for angles and hold times.
`timescale 1ns / 1ps

module sahs_cfg
  import sahs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_STANDBY_ANGLE: cfg_d.rest_angle         = cfg_wdata_i[AngleW-1:0];
        CFG_CLOSED_ANGLE:  cfg_d.close_angle        = cfg_wdata_i[AngleW-1:0];
        CFG_OPEN_ANGLE:    cfg_d.open_angle         = cfg_wdata_i[AngleW-1:0];
        CFG_SOS_ANGLE:     cfg_d.help_angle         = cfg_wdata_i[AngleW-1:0];
        CFG_CURTAIN_HOLD:  cfg_d.curtain_hold_ticks = cfg_wdata_i[TicksW-1:0];
        CFG_SOS_HOLD:      cfg_d.sos_hold_ticks     = cfg_wdata_i[TicksW-1:0];
        CFG_STOP_HOLD:     cfg_d.stop_hold_ticks    = cfg_wdata_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_angle         <= StandbyAngleRst;
      cfg_q.close_angle        <= ClosedAngleRst;
      cfg_q.open_angle         <= OpenAngleRst;
      cfg_q.help_angle         <= SosAngleRst;
      cfg_q.curtain_hold_ticks <= CurtainHoldRst;
      cfg_q.sos_hold_ticks     <= SosHoldRst;
      cfg_q.stop_hold_ticks    <= StopHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/sahs_core.sv =====
// Sequencer state and its registered update for one transaction.
`timescale 1ns / 1ps

module sahs_core
  import sahs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  phase_e            phase_d, phase_q;
  held_cmd_e         held_d, held_q;
  logic [TicksW-1:0] remain_d, remain_q;
  logic              attached_d, attached_q;
  logic [AngleW-1:0] angle_d, angle_q;
  logic              wrote;

  // Request decode
  logic              do_launch, do_standby;
  held_cmd_e         launch_cmd;
  logic [AngleW-1:0] launch_angle;
  logic [TicksW-1:0] launch_hold;
  logic [TicksW-1:0] remain_dec;

  always_comb begin
    do_launch    = 1'b0;
    do_standby   = 1'b0;
    launch_cmd   = HELD_CLOSE;
    launch_angle = cfg_i.close_angle;
    launch_hold  = cfg_i.curtain_hold_ticks;
    case (in_cmd_e'(item_i.cmd))
      CMD_CURTAIN: begin
        if (!item_i.enable_flag) begin
          do_standby = 1'b1;
        end else begin
          do_launch = 1'b1;
          if (!item_i.condition) begin
            launch_cmd   = HELD_OPEN;
            launch_angle = cfg_i.open_angle;
          end
        end
      end
      CMD_HELP: begin
        launch_cmd   = HELD_HELP;
        launch_angle = cfg_i.help_angle;
        launch_hold  = cfg_i.sos_hold_ticks;
        if (item_i.enable_flag && item_i.condition) begin
          do_launch = 1'b1;
        end else if (held_q == HELD_HELP) begin
          do_standby = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Saturating countdown for ticks
  assign remain_dec = (remain_q != '0) ? remain_q - TicksW'(1) : '0;

  // Next state
  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    remain_d   = remain_q;
    attached_d = attached_q;
    angle_d    = angle_q;
    wrote      = 1'b0;

    if (in_cmd_e'(item_i.cmd) == CMD_TICK) begin
      remain_d = remain_dec;
      if (remain_dec == '0) begin
        case (phase_q)
          PH_MOVING: begin
            attached_d = 1'b1;
            angle_d    = cfg_i.rest_angle;
            wrote      = 1'b1;
            phase_d    = PH_STOPPING;
            remain_d   = cfg_i.stop_hold_ticks;
          end
          PH_STOPPING: begin
            attached_d = 1'b0;
            phase_d    = PH_IDLE;
          end
          default: ;
        endcase
      end
    end else if (do_launch) begin
      // a repeat of the latched command is ignored
      if (held_q != launch_cmd) begin
        held_d     = launch_cmd;
        attached_d = 1'b1;
        angle_d    = launch_angle;
        wrote      = 1'b1;
        phase_d    = PH_MOVING;
        remain_d   = launch_hold;
      end
    end else if (do_standby) begin
      if (held_q == HELD_NONE) begin
        if (phase_q == PH_IDLE) begin
          attached_d = 1'b0;
        end
      end else begin
        held_d     = HELD_NONE;
        attached_d = 1'b1;
        angle_d    = cfg_i.rest_angle;
        wrote      = 1'b1;
        phase_d    = PH_STOPPING;
        remain_d   = cfg_i.stop_hold_ticks;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_STOPPING;
      held_q     <= HELD_NONE;
      remain_q   <= StopHoldRst;
      attached_q <= 1'b1;
      angle_q    <= StandbyAngleRst;
    end else if (step_i) begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      remain_q   <= remain_d;
      attached_q <= attached_d;
      angle_q    <= angle_d;
    end
  end

  // Result reflects the state after this transaction
  assign result_o.servo_angle    = angle_d;
  assign result_o.angle_written  = wrote;
  assign result_o.drive_attached = attached_d;
  assign result_o.moving         = (phase_d == PH_MOVING);
  assign result_o.held_command   = held_d;

endmodule

// ===== hw/rtl/servo_action_hold_sequencer.sv =====
// Top level of the servo action/hold sequencer: input and result registers.
`timescale 1ns / 1ps

// Servo action/hold sequencer. Each input transaction is a 1 ms tick, a
// curtain request or a help request, and yields exactly one result with the
// commanded angle, whether a new angle was written, the drive attach state,
// the moving flag and the latched command. One transaction is accepted per
// clock cycle; each passes the input register, then the state update into
// the result register, which offers the result, and the rate is held as
// long as the result side takes one result per cycle. The user must write
// configuration through cfg_we_i/cfg_idx_i/cfg_wdata_i only while no
// transaction is in flight; the block itself does not enforce this. Indexes
// past the register list are ignored. After reset the servo stands at 90
// degrees with the drive attached and releases it after 500 ticks.
module servo_action_hold_sequencer
  import sahs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sahs_in_if.sink             in_i,
  sahs_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  result_t res_d, res_q;
  logic    out_vld_q;
  logic    out_free, advance;

  sahs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline handshake
  assign out_free   = !out_vld_q || out_o.ready;
  assign advance    = in_vld_q && out_free;
  assign in_i.ready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.cmd         <= in_i.cmd;
      item_q.enable_flag <= in_i.enable_flag;
      item_q.condition   <= in_i.condition;
    end
  end

  sahs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.servo_angle    = res_q.servo_angle;
  assign out_o.angle_written  = res_q.angle_written;
  assign out_o.drive_attached = res_q.drive_attached;
  assign out_o.moving         = res_q.moving;
  assign out_o.held_command   = res_q.held_command;

endmodule

// ===== test/servo_status_checker.sv =====
// Checker for the servo sequencer: predicts each status transaction and compares results.
`timescale 1ns / 1ps

module servo_status_checker
  import sahs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sahs_in_if                  in_i,
  sahs_out_if                 out_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         outstanding_o,
  output int unsigned         mismatches_o
);

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    phase_e            phase;
    held_cmd_e         held;
    logic [TicksW-1:0] remain;
    logic              attached;
    logic [AngleW-1:0] angle;
  } servo_state_t;

  servo_state_t servo_q;
  cfg_t         cfg_q;
  result_t      expected_status_q[$];
  int unsigned  mismatch_cnt;

  // Next servo state and reported status for one request or tick
  function automatic result_t advance_servo(input servo_state_t cur, input cfg_t c,
                                            input item_t it, output servo_state_t nxt);
    logic              to_standby;
    logic              start_cmd;
    held_cmd_e         want;
    logic [AngleW-1:0] want_angle;
    logic [TicksW-1:0] want_hold;
    logic              wrote;
    result_t           res;
    nxt        = cur;
    to_standby = 1'b0;
    start_cmd  = 1'b0;
    want       = HELD_NONE;
    want_angle = '0;
    want_hold  = '0;
    wrote      = 1'b0;

    case (it.cmd)
      CMD_TICK: begin
        // countdown saturates at zero, then the phase moves on
        if (nxt.remain != '0) nxt.remain = nxt.remain - 1'b1;
        if (nxt.remain == '0) begin
          if (nxt.phase == PH_MOVING) begin
            nxt.attached = 1'b1;
            nxt.angle    = c.rest_angle;
            wrote        = 1'b1;
            nxt.phase    = PH_STOPPING;
            nxt.remain   = c.stop_hold_ticks;
          end else if (nxt.phase == PH_STOPPING) begin
            nxt.attached = 1'b0;
            nxt.phase    = PH_IDLE;
          end
        end
      end
      CMD_CURTAIN: begin
        if (!it.enable_flag) begin
          to_standby = 1'b1;
        end else begin
          start_cmd = 1'b1;
          want_hold = c.curtain_hold_ticks;
          if (it.condition) begin
            want       = HELD_CLOSE;
            want_angle = c.close_angle;
          end else begin
            want       = HELD_OPEN;
            want_angle = c.open_angle;
          end
        end
      end
      CMD_HELP: begin
        if (it.enable_flag && it.condition) begin
          start_cmd  = 1'b1;
          want       = HELD_HELP;
          want_angle = c.help_angle;
          want_hold  = c.sos_hold_ticks;
        end else if (nxt.held == HELD_HELP) begin
          to_standby = 1'b1;
        end
      end
      default: ; // unused code leaves everything alone
    endcase

    // forced standby; with nothing latched only an idle servo lets go of the drive
    if (to_standby) begin
      if (nxt.held == HELD_NONE) begin
        if (nxt.phase == PH_IDLE) nxt.attached = 1'b0;
      end else begin
        nxt.held     = HELD_NONE;
        nxt.attached = 1'b1;
        nxt.angle    = c.rest_angle;
        wrote        = 1'b1;
        nxt.phase    = PH_STOPPING;
        nxt.remain   = c.stop_hold_ticks;
      end
    end

    // a new command only starts when it differs from the latched one
    if (start_cmd && nxt.held != want) begin
      nxt.held     = want;
      nxt.attached = 1'b1;
      nxt.angle    = want_angle;
      wrote        = 1'b1;
      nxt.phase    = PH_MOVING;
      nxt.remain   = want_hold;
    end

    res.servo_angle    = nxt.angle;
    res.angle_written  = wrote;
    res.drive_attached = nxt.attached;
    res.moving         = (nxt.phase == PH_MOVING);
    res.held_command   = nxt.held;
    return res;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    item_t        it;
    result_t      got;
    result_t      want;
    servo_state_t nxt;
    if (!rst_ni) begin
      cfg_q.rest_angle           = StandbyAngleRst;
      cfg_q.close_angle          = ClosedAngleRst;
      cfg_q.open_angle           = OpenAngleRst;
      cfg_q.help_angle           = SosAngleRst;
      cfg_q.curtain_hold_ticks   = CurtainHoldRst;
      cfg_q.sos_hold_ticks       = SosHoldRst;
      cfg_q.stop_hold_ticks      = StopHoldRst;
      servo_q.phase              = PH_STOPPING;
      servo_q.held               = HELD_NONE;
      servo_q.remain             = StopHoldRst;
      servo_q.attached           = 1'b1;
      servo_q.angle              = StandbyAngleRst;
      expected_status_q.delete();
      mismatch_cnt               = 0;
    end else begin
      // result transaction against the oldest expectation
      if (out_i.valid && out_i.ready) begin
        got.servo_angle    = out_i.servo_angle;
        got.angle_written  = out_i.angle_written;
        got.drive_attached = out_i.drive_attached;
        got.moving         = out_i.moving;
        got.held_command   = out_i.held_command;
        if (expected_status_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportLimit)
            $display("%0t: unexpected result: ", $realtime,
                     "angle %0d written %0b attached %0b moving %0b held %0d",
                     got.servo_angle, got.angle_written, got.drive_attached,
                     got.moving, got.held_command);
        end else begin
          want = expected_status_q.pop_front();
          if (got.servo_angle !== want.servo_angle || got.angle_written !== want.angle_written ||
              got.drive_attached !== want.drive_attached || got.moving !== want.moving ||
              got.held_command !== want.held_command) begin
            mismatch_cnt++;
            if (mismatch_cnt <= ReportLimit)
              $display("%0t: mismatch: ", $realtime,
                       "expected angle %0d written %0b attached %0b moving %0b held %0d, ",
                       want.servo_angle, want.angle_written, want.drive_attached,
                       want.moving, want.held_command,
                       "got angle %0d written %0b attached %0b moving %0b held %0d",
                       got.servo_angle, got.angle_written, got.drive_attached,
                       got.moving, got.held_command);
          end
        end
      end

      // register writes, low bits only; spare indexes do nothing
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STANDBY_ANGLE: cfg_q.rest_angle         = cfg_wdata_i[AngleW-1:0];
          CFG_CLOSED_ANGLE:  cfg_q.close_angle        = cfg_wdata_i[AngleW-1:0];
          CFG_OPEN_ANGLE:    cfg_q.open_angle         = cfg_wdata_i[AngleW-1:0];
          CFG_SOS_ANGLE:     cfg_q.help_angle         = cfg_wdata_i[AngleW-1:0];
          CFG_CURTAIN_HOLD:  cfg_q.curtain_hold_ticks = cfg_wdata_i[TicksW-1:0];
          CFG_SOS_HOLD:      cfg_q.sos_hold_ticks     = cfg_wdata_i[TicksW-1:0];
          CFG_STOP_HOLD:     cfg_q.stop_hold_ticks    = cfg_wdata_i[TicksW-1:0];
          default: ;
        endcase
      end

      // input transaction: predict its status
      if (in_i.valid && in_i.ready) begin
        it.cmd         = in_i.cmd;
        it.enable_flag = in_i.enable_flag;
        it.condition   = in_i.condition;
        expected_status_q.push_back(advance_servo(servo_q, cfg_q, it, nxt));
        servo_q = nxt;
      end
    end
    outstanding_o <= expected_status_q.size();
    mismatches_o  <= mismatch_cnt;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the servo sequencer testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module testbench;
  import sahs_pkg::*;

  localparam logic [1:0]         CmdUnused   = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;
  localparam int unsigned        CycleLimit  = 200_000;
  localparam int unsigned        NumSegs     = 6;
  localparam int unsigned        SegItems    = 280;
  localparam int unsigned        LongStall   = 300;
  localparam int unsigned        DrainCycles = 8;

  // Short holds and out-of-range angle for the directed sequence
  localparam cfg_t DirectedCfg = '{
    rest_angle: 8'd90, close_angle: 8'd0, open_angle: 8'd180,
    help_angle: 8'd255, curtain_hold_ticks: 16'd2, sos_hold_ticks: 16'd0,
    stop_hold_ticks: 16'd1
  };
  // Longest holds: no hold started under them expires
  localparam cfg_t HoldMaxCfg = '{
    rest_angle: 8'd180, close_angle: 8'd255, open_angle: 8'd0,
    help_angle: 8'd180, curtain_hold_ticks: 16'hFFFF, sos_hold_ticks: 16'hFFFF,
    stop_hold_ticks: 16'hFFFF
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         outstanding;
  int unsigned         mismatches;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_idle_pct = 0;
  int unsigned         stall_reqs    = 0;
  int unsigned         stall_served  = 0;
  int unsigned         stall_left    = 0;
  int unsigned         cycle_cnt     = 0;

  sahs_in_if  in_if ();
  sahs_out_if out_if ();

  servo_action_hold_sequencer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  servo_status_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_i          (in_if),
    .out_i         (out_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_reqs != stall_served) begin
      out_if.ready <= 1'b0;
      stall_left   <= LongStall;
      stall_served <= stall_served + 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One input transaction, after a random gap
  task automatic send_item(input logic [1:0] cmd, input logic en, input logic cond);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.enable_flag <= en;
    in_if.condition   <= cond;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Stop sending and wait for every expected result
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data[CfgDataW-1:0];
    @(posedge clk);
  endtask

  // Angle registers get junk in the upper byte; the spare index is written too
  task automatic program_config(input cfg_t c);
    write_reg(CFG_STANDBY_ANGLE, ($urandom_range(255) << 8) | 32'(c.rest_angle));
    write_reg(CFG_CLOSED_ANGLE, ($urandom_range(255) << 8) | 32'(c.close_angle));
    write_reg(CFG_OPEN_ANGLE, ($urandom_range(255) << 8) | 32'(c.open_angle));
    write_reg(CFG_SOS_ANGLE, ($urandom_range(255) << 8) | 32'(c.help_angle));
    write_reg(CFG_CURTAIN_HOLD, 32'(c.curtain_hold_ticks));
    write_reg(CFG_SOS_HOLD, 32'(c.sos_hold_ticks));
    write_reg(CFG_STOP_HOLD, 32'(c.stop_hold_ticks));
    write_reg(CfgIdxSpare, $urandom);
    cfg_we <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    cfg_t        seg_cfg;
    int unsigned pick;
    logic [1:0]  cmd;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_TICK;
    in_if.enable_flag = 1'b0;
    in_if.condition   = 1'b0;
    out_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_STANDBY_ANGLE;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: state straight after reset
    send_item(CmdUnused, 1'b1, 1'b1);
    send_item(CMD_TICK, 1'b0, 1'b0);
    send_item(CMD_CURTAIN, 1'b0, 1'b1);
    send_item(CMD_HELP, 1'b1, 1'b0);
    wait_drained();
    program_config(DirectedCfg);

    // directed: close, repeat, expiry, repeat after expiry, release
    send_item(CMD_CURTAIN, 1'b1, 1'b1);
    send_item(CMD_CURTAIN, 1'b1, 1'b1);
    send_item(CMD_TICK, 1'b0, 1'b0);
    send_item(CMD_TICK, 1'b1, 1'b1);
    send_item(CMD_CURTAIN, 1'b1, 1'b1);
    send_item(CMD_TICK, 1'b0, 1'b0);
    // idle disable, open, help with zero hold
    send_item(CMD_CURTAIN, 1'b0, 1'b0);
    send_item(CMD_CURTAIN, 1'b1, 1'b0);
    send_item(CMD_HELP, 1'b1, 1'b1);
    send_item(CMD_TICK, 1'b0, 1'b0);
    send_item(CMD_HELP, 1'b1, 1'b1);
    send_item(CMD_HELP, 1'b0, 1'b1);
    send_item(CMD_TICK, 1'b0, 1'b0);
    send_item(CMD_HELP, 1'b0, 1'b0);
    send_item(CMD_CURTAIN, 1'b1, 1'b1);
    send_item(CMD_CURTAIN, 1'b0, 1'b1);
    send_item(CmdUnused, 1'b0, 1'b0);
    send_item(CMD_TICK, 1'b0, 1'b0);
    send_item(CMD_TICK, 1'b0, 1'b0);

    // random segments, each with its own settings and idling mix
    for (int seg = 0; seg < NumSegs; seg++) begin
      wait_drained();
      seg_cfg.rest_angle         = 8'($urandom_range(180));
      seg_cfg.close_angle        = 8'($urandom_range(180));
      seg_cfg.open_angle         = 8'($urandom_range(180));
      seg_cfg.help_angle         = 8'($urandom_range(180));
      seg_cfg.curtain_hold_ticks = 16'($urandom_range(6));
      seg_cfg.sos_hold_ticks     = 16'($urandom_range(6));
      seg_cfg.stop_hold_ticks    = 16'($urandom_range(6));
      if (seg == 1) begin
        seg_cfg = HoldMaxCfg;
      end else if (seg == 3) begin
        seg_cfg.curtain_hold_ticks = '0;
        seg_cfg.sos_hold_ticks     = '0;
        seg_cfg.stop_hold_ticks    = '0;
      end
      program_config(seg_cfg);
      if (seg < 2) begin
        send_idle_pct <= 19;
        recv_idle_pct <= 81;
      end else if (seg < 4) begin
        send_idle_pct <= 81;
        recv_idle_pct <= 19;
      end else begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end

      for (int n = 0; n < SegItems; n++) begin
        // long receiver hold-off while the sender keeps pushing
        if ((seg == 0 || seg == 4) && n == 40) stall_reqs <= stall_reqs + 1;
        // sender pause until all results are in
        if ((seg == 2 || seg == 5) && n == 140) wait_drained();
        pick = $urandom_range(99);
        if (pick < 45)      cmd = CMD_TICK;
        else if (pick < 70) cmd = CMD_CURTAIN;
        else if (pick < 93) cmd = CMD_HELP;
        else                cmd = CmdUnused;
        send_item(cmd, ($urandom_range(3) != 0), 1'($urandom_range(1)));
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
